// ===== rtl/iff_pkg.sv =====
package iff_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SEP,
    ST_LEN,
    ST_PAD,
    ST_EMIT
  } state_e;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_APOS  = 2'd1;
  localparam logic [1:0] SEP_COMMA = 2'd2;
  localparam logic [1:0] SEP_UNDER = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [3:0] DEC_BASE = 4'd10;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d >= DEC_BASE) begin
      c = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0, d - DEC_BASE};
    end else begin
      c = CH_ZERO + {4'b0, d};
    end
    return c;
  endfunction

  function automatic logic [7:0] sep_char(input logic [1:0] s);
    logic [7:0] c;
    case (s)
      SEP_APOS:  c = CH_APOS;
      SEP_COMMA: c = CH_COMMA;
      SEP_UNDER: c = CH_UNDER;
      default:   c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/iff_ram.sv =====
module iff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/integer_field_formatter.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  value_i .. group_sep_i (one request)
// out      output     out_valid_o / out_stall_i out_char_o, last_o, field_count_o
//
// Binary, octal and hex write one digit per ST_DIGIT state; decimal first runs a
// bit-serial division by ten in ST_DIV for each digit. Each separator takes an
// ST_SEP state. ST_LEN and ST_PAD set up the field, then pad and sign characters
// are emitted directly and digit characters via a registered read of the digit RAM.
// A new request is taken once the last character sits in the output register.
// Reset clears the state machine, counters and output valid; no RAM clearing.
module integer_field_formatter #(
  parameter int MAX_FIELD  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  is_long_i,
  input  logic                  is_signed_i,
  input  logic [1:0]            radix_sel_i,
  input  logic                  upper_hex_i,
  input  logic [6:0]            field_width_i,
  input  logic signed [7:0]     precision_i,
  input  logic                  zero_pad_i,
  input  logic [1:0]            sign_mode_i,
  input  logic                  left_justify_i,
  input  logic [1:0]            group_sep_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_o,
  output logic [6:0]            field_count_o
);

  import iff_pkg::*;

  localparam int STORE_DEPTH = VALUE_BITS + VALUE_BITS / 2;
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int NW    = $clog2(STORE_DEPTH + 1);
  localparam int BW    = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(MAX_FIELD + STORE_DEPTH + 130);

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [3:0]            rem_q, rem_d;
  logic [BW-1:0]         bc_q, bc_d;
  logic [1:0]            grp_q, grp_d;
  logic [NW-1:0]         n_q, n_d;
  logic [NW-1:0]         rd_q, rd_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [CNT_W-1:0]      pad_left_q, pad_left_d;
  logic [CNT_W-1:0]      data_left_q, data_left_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [7:0]            sign_q, sign_d;

  logic       neg_q, upper_q, zpad_q, lj_q;
  logic [1:0] radix_q, smode_q, sep_q;
  logic [6:0] fw_q;
  logic [7:0] prec_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic [6:0] out_count_q, out_count_d;

  logic                  accept;
  logic [VALUE_BITS-1:0] in_masked, in_mask, in_mag;
  logic                  in_neg;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [7:0]            ram_wdata;
  logic [NW-1:0]         raddr_full;
  logic [7:0]            ram_rdata;

  logic [4:0]            div_t;
  logic                  div_ge;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] mag_nx;
  logic [CNT_W-1:0]      len;

  logic       emit_sign, emit_pad, emit_digit, out_free, load;
  logic [CNT_W-1:0] pad_after, data_after;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign in_mask   = is_long_i ? '1 : VALUE_BITS'(16'hFFFF);
  assign in_masked = value_i & in_mask;
  assign in_neg    = is_signed_i && (is_long_i ? value_i[VALUE_BITS-1] : value_i[15]);
  assign in_mag    = in_neg ? (((~in_masked) + VALUE_BITS'(1)) & in_mask) : in_masked;

  assign div_t  = {rem_q, mag_q[VALUE_BITS-1]};
  assign div_ge = (div_t >= {1'b0, DEC_BASE});

  always_comb begin
    case (radix_q)
      RADIX_BIN: begin
        dig    = {3'b0, mag_q[0]};
        mag_nx = mag_q >> 1;
      end
      RADIX_OCT: begin
        dig    = {1'b0, mag_q[2:0]};
        mag_nx = mag_q >> 3;
      end
      RADIX_HEX: begin
        dig    = mag_q[3:0];
        mag_nx = mag_q >> 4;
      end
      default: begin
        dig    = rem_q;
        mag_nx = mag_q;
      end
    endcase
  end

  always_comb begin
    len = CNT_W'(n_q) + CNT_W'(sign_d != CH_NUL);
    if (!prec_q[7] && (len > CNT_W'(prec_q[6:0]))) begin
      len = CNT_W'(prec_q[6:0]);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    emit_sign  = 1'b0;
    emit_pad   = 1'b0;
    emit_digit = 1'b0;
    if (!lj_q && (pad_left_q != '0)) begin
      if ((data_left_q != '0) && (sign_q != CH_NUL) && zpad_q) begin
        emit_sign = 1'b1;
      end else begin
        emit_pad = 1'b1;
      end
    end else if (data_left_q != '0) begin
      if (sign_q != CH_NUL) begin
        emit_sign = 1'b1;
      end else begin
        emit_digit = 1'b1;
      end
    end else begin
      emit_pad = 1'b1;
    end
  end

  assign pad_after  = emit_pad ? pad_left_q - CNT_W'(1) : pad_left_q;
  assign data_after = emit_pad ? data_left_q : data_left_q - CNT_W'(1);
  assign load = (state_q == ST_EMIT) && out_free && !(emit_digit && !rd_ok_q);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    bc_d        = bc_q;
    grp_d       = grp_q;
    n_d         = n_q;
    rd_d        = rd_q;
    rd_ok_d     = 1'b1;
    pad_left_d  = pad_left_q;
    data_left_d = data_left_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    ram_we      = 1'b0;
    ram_waddr   = n_q[AW-1:0];
    ram_wdata   = digit_char(dig, upper_q);
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_count_d = out_count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mag_d   = in_mag;
          rem_d   = '0;
          bc_d    = '0;
          grp_d   = '0;
          n_d     = '0;
          state_d = (radix_sel_i == RADIX_DEC) ? ST_DIV : ST_DIGIT;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? 4'(div_t - {1'b0, DEC_BASE}) : div_t[3:0];
        mag_d = {mag_q[VALUE_BITS-2:0], div_ge};
        bc_d  = bc_q + BW'(1);
        if (bc_q == BW'(VALUE_BITS - 1)) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (n_q < NW'(STORE_DEPTH)) begin
          ram_we = 1'b1;
          n_d    = n_q + NW'(1);
        end
        mag_d = mag_nx;
        rem_d = '0;
        bc_d  = '0;
        if (mag_nx == '0) begin
          state_d = ST_LEN;
        end else if ((sep_q != SEP_NONE) && (grp_q == 2'd2)) begin
          grp_d   = '0;
          state_d = ST_SEP;
        end else begin
          if (sep_q != SEP_NONE) begin
            grp_d = grp_q + 2'd1;
          end
          state_d = (radix_q == RADIX_DEC) ? ST_DIV : ST_DIGIT;
        end
      end
      ST_SEP: begin
        ram_wdata = sep_char(sep_q);
        if (n_q < NW'(STORE_DEPTH)) begin
          ram_we = 1'b1;
          n_d    = n_q + NW'(1);
        end
        state_d = (radix_q == RADIX_DEC) ? ST_DIV : ST_DIGIT;
      end
      ST_LEN: begin
        if (neg_q) begin
          sign_d = CH_MINUS;
        end else if (smode_q == SIGN_PLUS) begin
          sign_d = CH_PLUS;
        end else if (smode_q == SIGN_SPACE) begin
          sign_d = CH_SPACE;
        end else begin
          sign_d = CH_NUL;
        end
        data_left_d = len;
        cnt_d = (int'(fw_q) > MAX_FIELD) ? CNT_W'(MAX_FIELD) : CNT_W'(fw_q);
        state_d = ST_PAD;
      end
      ST_PAD: begin
        if (cnt_q > data_left_q) begin
          pad_left_d = cnt_q - data_left_q;
        end else begin
          pad_left_d = '0;
          cnt_d      = data_left_q;
        end
        rd_d    = '0;
        rd_ok_d = 1'b0;
        state_d = ((cnt_q == '0) && (data_left_q == '0)) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        rd_ok_d = rd_ok_q;
        if (load) begin
          out_valid_d = 1'b1;
          out_last_d  = (pad_after == '0) && (data_after == '0);
          out_count_d = cnt_q[6:0];
          pad_left_d  = pad_after;
          data_left_d = data_after;
          if (emit_pad) begin
            out_char_d = zpad_q ? CH_ZERO : CH_SPACE;
          end else if (emit_sign) begin
            out_char_d = sign_q;
            sign_d     = CH_NUL;
          end else begin
            out_char_d = ram_rdata;
            rd_d       = rd_q + NW'(1);
            rd_ok_d    = 1'b0;
          end
          if ((pad_after == '0) && (data_after == '0)) begin
            state_d = ST_IDLE;
          end
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign raddr_full = n_q - NW'(1) - rd_q;

  iff_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bc_q        <= '0;
      grp_q       <= '0;
      n_q         <= '0;
      rd_q        <= '0;
      rd_ok_q     <= 1'b0;
      pad_left_q  <= '0;
      data_left_q <= '0;
      cnt_q       <= '0;
      sign_q      <= CH_NUL;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bc_q        <= bc_d;
      grp_q       <= grp_d;
      n_q         <= n_d;
      rd_q        <= rd_d;
      rd_ok_q     <= rd_ok_d;
      pad_left_q  <= pad_left_d;
      data_left_q <= data_left_d;
      cnt_q       <= cnt_d;
      sign_q      <= sign_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    rem_q       <= rem_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_count_q <= out_count_d;
    if (accept) begin
      neg_q   <= in_neg;
      upper_q <= upper_hex_i;
      zpad_q  <= zero_pad_i;
      lj_q    <= left_justify_i;
      radix_q <= radix_sel_i;
      smode_q <= sign_mode_i;
      sep_q   <= group_sep_i;
      fw_q    <= field_width_i;
      prec_q  <= precision_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_o        = out_last_q;
  assign field_count_o = out_count_q;

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (pad_left_q != '0) || (data_left_q != '0))
    else $error("emission running with nothing left");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (n_q < NW'(STORE_DEPTH)))
    else $error("digit store write beyond depth");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && emit_digit |-> (rd_q < n_q))
    else $error("digit read beyond stored digits");

endmodule
